// ----- sv/pls_pkg.sv -----
package pls_pkg;

  localparam int DEF_CAPACITY   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam int OP_BITS     = 3;
  localparam int POS_BITS    = 6;
  localparam int PORT_BITS   = 32;
  localparam int COUNT_BITS  = 6;

  typedef enum logic [OP_BITS-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // decision for one request, from control to the entry cells and result stage
  typedef struct packed {
    logic    ins;     // insert taken
    logic    rem;     // removal taken
    status_t status;
  } plan_t;

endpackage

// ----- sv/positional_list_store.sv -----
// Channel   Dir  Handshake               Payload
// request   in   start & !busy           op, position, value
// result    out  done (one-cycle strobe) removed_value, removed_valid, status, entry_count
//
// One item per cycle. An accepted item is registered, then decoded and
// applied to the entry cells in the next cycle; its result is registered
// together with that cell update. The count update of one item is seen by the
// item right behind it, so back-to-back items need no stall.
// rst (synchronous) clears the count and the pipeline; busy is high only
// in reset. The result side cannot stall: each result shows for one cycle.
module positional_list_store import pls_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_BITS-1:0]    op,
  input  logic [POS_BITS-1:0]   position,
  input  logic [PORT_BITS-1:0]  value,
  output logic                  done,
  output logic [PORT_BITS-1:0]  removed_value,
  output logic                  removed_valid,
  output logic [1:0]            status,
  output logic [COUNT_BITS-1:0] entry_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (VALUE_BITS > PORT_BITS) ? VALUE_BITS : PORT_BITS;
  localparam int NW = (CW > COUNT_BITS) ? CW : COUNT_BITS;

  // request register
  logic                  req_valid;
  logic [OP_BITS-1:0]    req_op;
  logic [POS_BITS-1:0]   req_pos;
  logic [VALUE_BITS-1:0] req_value;

  plan_t                 plan;
  logic [IW-1:0]         eff_pos;
  logic [CW-1:0]         count_next;
  logic [VALUE_BITS-1:0] got;
  logic [XW-1:0]         value_x;
  logic [XW-1:0]         got_x;
  logic [NW-1:0]         count_x;

  assign busy    = rst;
  assign value_x = XW'(value);
  assign got_x   = XW'(got);
  assign count_x = NW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
    req_op    <= op;
    req_pos   <= position;
    req_value <= value_x[VALUE_BITS-1:0];   // keep the low VALUE_BITS bits
  end

  pls_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_op     (req_op),
    .req_pos    (req_pos),
    .plan       (plan),
    .pos        (eff_pos),
    .count_next (count_next)
  );

  pls_cells #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .IW         (IW)
  ) u_cells (
    .clk  (clk),
    .plan (plan),
    .pos  (eff_pos),
    .din  (req_value),
    .dout (got)
  );

  // result register; removed fields are zero unless a removal was taken
  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      removed_valid <= 1'b0;
    end else begin
      done          <= req_valid;
      removed_valid <= plan.rem;
    end
    removed_value <= plan.rem ? got_x[PORT_BITS-1:0] : '0;
    status        <= plan.status;
    entry_count   <= count_x[COUNT_BITS-1:0];
  end

endmodule

// ----- sv/pls_ctrl.sv -----
module pls_ctrl import pls_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int IW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [OP_BITS-1:0]  req_op,
  input  logic [POS_BITS-1:0] req_pos,
  output plan_t               plan,
  output logic [IW-1:0]       pos,
  output logic [CW-1:0]       count_next
);

  localparam int WW = (CW > POS_BITS) ? CW : POS_BITS;

  logic [CW-1:0] count;
  logic [WW-1:0] cnt_w;
  logic [WW-1:0] pos_w;
  logic [WW-1:0] target;

  always_comb begin
    cnt_w  = WW'(count);
    pos_w  = WW'(req_pos);
    target = '0;
    plan   = '{ins: 1'b0, rem: 1'b0, status: ST_BAD};
    case (req_op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (req_op == OP_INS_FRONT) begin
          target = '0;
        end else if (req_op == OP_INS_BACK) begin
          target = cnt_w;
        end else begin
          target = pos_w;
        end
        // position check wins over the full check
        if (target > cnt_w) begin
          plan.status = ST_BAD;
        end else if (count == CW'(CAPACITY)) begin
          plan.status = ST_FULL;
        end else begin
          plan.status = ST_DONE;
          plan.ins    = 1'b1;
        end
      end
      OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
        if (req_op == OP_REM_FRONT) begin
          target = '0;
        end else if (req_op == OP_REM_BACK) begin
          target = cnt_w - WW'(1);
        end else begin
          target = pos_w;
        end
        if (count != '0 && target < cnt_w) begin
          plan.status = ST_DONE;
          plan.rem    = 1'b1;
        end
      end
      default: begin
        plan.status = ST_BAD;
      end
    endcase
    if (!req_valid) begin
      plan.ins = 1'b0;
      plan.rem = 1'b0;
    end
    pos = IW'(target);
    if (plan.ins) begin
      count_next = count + CW'(1);
    end else if (plan.rem) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ----- sv/pls_cells.sv -----
module pls_cells import pls_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int IW         = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  plan_t                 plan,
  input  logic [IW-1:0]         pos,
  input  logic [VALUE_BITS-1:0] din,
  output logic [VALUE_BITS-1:0] dout
);

  logic [VALUE_BITS-1:0] entries      [CAPACITY];
  logic [VALUE_BITS-1:0] entries_next [CAPACITY];

  // every cell compares its own index with the position and picks
  // itself, the new value or a neighbor
  always_comb begin
    logic below;
    logic at;
    dout = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      below = IW'(i) < pos;
      at    = IW'(i) == pos;
      if (at) begin
        dout = dout | entries[i];
      end
      if (below) begin
        entries_next[i] = entries[i];
      end else if (plan.ins) begin
        entries_next[i] = at ? din : entries[(i > 0) ? i - 1 : 0];
      end else begin
        entries_next[i] = entries[(i + 1 < CAPACITY) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (plan.ins || plan.rem) begin
      entries <= entries_next;
    end
  end

endmodule

// ----- sv/pls_checker.sv -----
module pls_checker import pls_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic [PORT_BITS-1:0]  removed_value,
  input logic                  removed_valid,
  input logic [1:0]            status,
  input logic [COUNT_BITS-1:0] entry_count
);

  // every accepted item is followed by its done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without accepted item");

  a_removed: assert property (@(posedge clk) disable iff (rst)
    removed_valid |-> (done && status == ST_DONE))
    else $error("removed_valid outside a successful result");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !removed_valid) |-> removed_value == '0)
    else $error("removed_value not zero");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> entry_count == COUNT_BITS'(CAPACITY))
    else $error("full status with list not full");

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (.*);
